// File: rtl/core/btk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btk_pkg: shared types and constants of the beam top-k keeper
// Entry layout, command codes, controller states and the result record.
// ----------------------------------------------------------------------------
package btk_pkg;

    localparam int BeamMax = 16;
    localparam int IdxW    = (BeamMax > 1) ? $clog2(BeamMax) : 1;
    localparam int CntW    = $clog2(BeamMax + 1);
    localparam int CfgW    = 5;
    localparam int HeldW   = 5;
    localparam int EntryW  = 64;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_DRAIN = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [15:0]        action;
        logic [15:0]        source;
        logic signed [31:0] score;
    } entry_t;

    typedef struct packed {
        logic               inserted;
        logic [HeldW-1:0]   held_count;
        logic               entry_valid;
        entry_t             entry;
        logic               last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_REPLY
    } state_t;

endpackage
`default_nettype wire

// File: rtl/core/btk_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btk_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btk_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                              aclk,
    input  wire                              wr_en,
    input  wire  [$clog2(Depth > 1 ? Depth : 2)-1:0] wr_addr,
    input  wire  [Width-1:0]                 wr_data,
    input  wire  [$clog2(Depth > 1 ? Depth : 2)-1:0] rd_addr,
    output logic [Width-1:0]                 rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/core/btk_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btk_ctrl: sequencer of the beam top-k keeper
// Scans the entry memory for minima, shifts entries after an eviction and
// produces the results of clear, offer, drain and unused commands.
// ----------------------------------------------------------------------------
module btk_ctrl (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire  [btk_pkg::CntW-1:0]    cap,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire  [1:0]                  in_cmd,
    input  wire  btk_pkg::entry_t       in_entry,
    input  wire                         out_free,
    output logic                        res_load,
    output btk_pkg::result_t            res,
    output logic                        ram_we,
    output logic [btk_pkg::IdxW-1:0]    ram_waddr,
    output btk_pkg::entry_t             ram_wdata,
    output logic [btk_pkg::IdxW-1:0]    ram_raddr,
    input  wire  btk_pkg::entry_t       ram_rdata
);

    localparam int CntW = btk_pkg::CntW;
    localparam int IdxW = btk_pkg::IdxW;

    btk_pkg::state_t        state_reg, state_next;
    logic [CntW-1:0]        fill_reg, fill_next;
    btk_pkg::entry_t        new_reg, new_next;
    logic [CntW-1:0]        issue_reg, issue_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic [IdxW-1:0]        pend_idx_reg, pend_idx_next;
    logic                   found_reg, found_next;
    logic [IdxW-1:0]        min_idx_reg, min_idx_next;
    btk_pkg::entry_t        min_reg, min_next;
    logic [btk_pkg::BeamMax-1:0] emitted_reg, emitted_next;
    logic [CntW-1:0]        left_reg, left_next;
    logic                   drain_reg, drain_next;
    logic [IdxW-1:0]        sh_reg, sh_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= btk_pkg::ST_IDLE;
            fill_reg     <= '0;
            pend_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            pend_vld_reg <= pend_vld_next;
        end
        new_reg      <= new_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        min_idx_reg  <= min_idx_next;
        min_reg      <= min_next;
        emitted_reg  <= emitted_next;
        left_reg     <= left_next;
        drain_reg    <= drain_next;
        sh_reg       <= sh_next;
    end

    always_comb begin
        logic skip;
        logic [CntW-1:0] sh_plus;
        state_next    = state_reg;
        fill_next     = fill_reg;
        new_next      = new_reg;
        issue_next    = issue_reg;
        pend_vld_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        min_idx_next  = min_idx_reg;
        min_next      = min_reg;
        emitted_next  = emitted_reg;
        left_next     = left_reg;
        drain_next    = drain_reg;
        sh_next       = sh_reg;
        in_ready      = 1'b0;
        res_load      = 1'b0;
        res           = '0;
        res.last      = 1'b1;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = in_entry;
        ram_raddr     = issue_reg[IdxW-1:0];
        skip          = 1'b0;
        sh_plus       = CntW'(sh_reg) + CntW'(1);

        unique case (state_reg)
            btk_pkg::ST_IDLE: begin
                in_ready = out_free;
                if (in_valid && out_free) begin
                    issue_next = '0;
                    found_next = 1'b0;
                    new_next   = in_entry;
                    case (in_cmd)
                        btk_pkg::CMD_CLEAR: begin
                            fill_next = '0;
                            res_load  = 1'b1;
                        end
                        btk_pkg::CMD_OFFER: begin
                            if (fill_reg < cap) begin
                                ram_we         = 1'b1;
                                ram_waddr      = fill_reg[IdxW-1:0];
                                fill_next      = fill_reg + CntW'(1);
                                res.inserted   = 1'b1;
                                res.held_count = btk_pkg::HeldW'(fill_reg + CntW'(1));
                                res_load       = 1'b1;
                            end else begin
                                drain_next = 1'b0;
                                state_next = btk_pkg::ST_SCAN;
                            end
                        end
                        btk_pkg::CMD_DRAIN: begin
                            if (fill_reg == '0) begin
                                res_load = 1'b1;
                            end else begin
                                drain_next   = 1'b1;
                                emitted_next = '0;
                                left_next    = fill_reg;
                                state_next   = btk_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            res.held_count = btk_pkg::HeldW'(fill_reg);
                            res_load       = 1'b1;
                        end
                    endcase
                end
            end

            btk_pkg::ST_SCAN: begin
                // Reads go out one slot per cycle; each compare uses the data
                // of the read issued in the cycle before.
                if (issue_reg < fill_reg) begin
                    issue_next    = issue_reg + CntW'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = issue_reg[IdxW-1:0];
                end
                if (pend_vld_reg) begin
                    skip = drain_reg && emitted_reg[pend_idx_reg];
                    if (!skip && (!found_reg || (ram_rdata.score < min_reg.score))) begin
                        found_next   = 1'b1;
                        min_next     = ram_rdata;
                        min_idx_next = pend_idx_reg;
                    end
                    if (CntW'(pend_idx_reg) + CntW'(1) == fill_reg) begin
                        state_next = btk_pkg::ST_PICK;
                    end
                end
            end

            btk_pkg::ST_PICK: begin
                if (drain_reg) begin
                    if (out_free) begin
                        res.entry_valid = 1'b1;
                        res.entry       = min_reg;
                        res.held_count  = btk_pkg::HeldW'(left_reg - CntW'(1));
                        res.last        = (left_reg == CntW'(1));
                        res_load        = 1'b1;
                        emitted_next[min_idx_reg] = 1'b1;
                        left_next       = left_reg - CntW'(1);
                        issue_next      = '0;
                        found_next      = 1'b0;
                        if (left_reg == CntW'(1)) begin
                            fill_next  = '0;
                            state_next = btk_pkg::ST_IDLE;
                        end else begin
                            state_next = btk_pkg::ST_SCAN;
                        end
                    end
                end else if (new_reg.score > min_reg.score) begin
                    sh_next    = min_idx_reg;
                    state_next = btk_pkg::ST_SHIFT_RD;
                end else begin
                    state_next = btk_pkg::ST_REPLY;
                end
            end

            btk_pkg::ST_SHIFT_RD: begin
                // Entries after the evicted one close up so that slot order
                // stays arrival order; the newcomer takes the last slot.
                if (sh_plus < fill_reg) begin
                    ram_raddr  = sh_plus[IdxW-1:0];
                    state_next = btk_pkg::ST_SHIFT_WR;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = sh_reg;
                    ram_wdata  = new_reg;
                    state_next = btk_pkg::ST_REPLY;
                end
            end

            btk_pkg::ST_SHIFT_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = sh_reg;
                ram_wdata  = ram_rdata;
                sh_next    = sh_plus[IdxW-1:0];
                state_next = btk_pkg::ST_SHIFT_RD;
            end

            btk_pkg::ST_REPLY: begin
                if (out_free) begin
                    res.held_count = btk_pkg::HeldW'(fill_reg);
                    res_load       = 1'b1;
                    state_next     = btk_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = btk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/beam_top_k_keeper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// beam_top_k_keeper: keeps the best-scoring candidates of one search step
// Entries live in one RAM in arrival order; a sequencer scans and shifts it.
// ----------------------------------------------------------------------------
// Latency: clear, unused command, empty drain and a non-full offer give their
//   result in the cycle after the transfer. A full offer shows it after a scan
//   of all held entries, plus a shift of the later entries when it evicts.
// Throughput: one item at a time; a drain rescans all held entries for each
//   minimum it emits, through the single RAM read port.
// Reset: synchronous, active low; the set is empty and the capacity is 16.
module beam_top_k_keeper (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_wr_en,
    input  wire  [4:0]   cfg_wr_data,
    input  wire          s_tvalid,
    output logic         s_tready,
    // score[31:0], source_slot[47:32], action_code[63:48]
    input  wire  [63:0]  s_tdata,
    // command[1:0]
    input  wire  [1:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // inserted[0], held_count[5:1], entry_score[37:6], entry_source[53:38],
    // entry_action[69:54], zero fill[71:70]
    output logic [71:0]  m_tdata,
    // entry_valid[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    localparam int CntW = btk_pkg::CntW;
    localparam int IdxW = btk_pkg::IdxW;

    logic [btk_pkg::CfgW-1:0] cfg_reg;
    logic [CntW-1:0]          cap;
    logic                     out_valid_reg;
    btk_pkg::result_t         out_reg;
    logic                     out_free;
    logic                     res_load;
    btk_pkg::result_t         res;
    logic                     ram_we;
    logic [IdxW-1:0]          ram_waddr, ram_raddr;
    btk_pkg::entry_t          ram_wdata, ram_rdata, in_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= btk_pkg::CfgW'(16);
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // A capacity of zero acts as one; values above the store depth saturate.
    always_comb begin
        if (cfg_reg == '0) begin
            cap = CntW'(1);
        end else if (int'(cfg_reg) > btk_pkg::BeamMax) begin
            cap = CntW'(btk_pkg::BeamMax);
        end else begin
            cap = CntW'(cfg_reg);
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_load) begin
            out_reg <= res;
        end
    end

    assign in_entry.score  = s_tdata[31:0];
    assign in_entry.source = s_tdata[47:32];
    assign in_entry.action = s_tdata[63:48];

    btk_ram #(
        .Width (btk_pkg::EntryW),
        .Depth (btk_pkg::BeamMax)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    btk_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cap       (cap),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_entry  (in_entry),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.entry.action, out_reg.entry.source,
                       out_reg.entry.score, out_reg.held_count, out_reg.inserted};
    assign m_tuser  = out_reg.entry_valid;
    assign m_tlast  = out_reg.last;

endmodule
`default_nettype wire

// File: rtl/core/btk_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btk_checker: port-level checks of the beam top-k keeper
// Watches the result stream for reset, stall and framing behavior.
// ----------------------------------------------------------------------------
module btk_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [71:0]  m_tdata,
    input wire [0:0]   m_tuser,
    input wire         m_tlast
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && m_tlast |-> m_tdata[5:1] == 5'd0)
        else $error("final drained entry leaves entries behind");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("result without entry is not the final one");

endmodule

bind beam_top_k_keeper btk_checker u_btk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
